>>> rtl/rpds_pkg.sv
// rpds_pkg: shared types, codes and constants of the radio packet dma sequencer
// no dependencies; used by every rtl file of the block
package rpds_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_RESULTS = 4;
  localparam int CountW      = $clog2(MAX_RESULTS + 1);
  localparam int SlotW       = $clog2(MAX_RESULTS);

  // commands
  localparam logic [1:0] CMD_RX_POLL  = 2'd0;
  localparam logic [1:0] CMD_TX_POLL  = 2'd1;
  localparam logic [1:0] CMD_TX_START = 2'd2;

  // radio actions
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_RD_SHORT = 3'd1;
  localparam logic [2:0] ACT_WR_SHORT = 3'd2;
  localparam logic [2:0] ACT_RD_LONG  = 3'd3;
  localparam logic [2:0] ACT_DMA_IN   = 3'd4;
  localparam logic [2:0] ACT_DMA_OUT  = 3'd5;

  // radio addresses
  localparam logic [9:0] ADDR_INTSTAT = 10'h031;
  localparam logic [9:0] ADDR_BBREG1  = 10'h039;
  localparam logic [9:0] ADDR_TXNCON  = 10'h01B;
  localparam logic [9:0] ADDR_TXSTAT  = 10'h024;
  localparam logic [9:0] ADDR_RXFIFO  = 10'h300;
  localparam logic [9:0] ADDR_TXNFIFO = 10'h000;

  localparam logic [7:0] TXN_TRIGGER = 8'b0000_0101;
  localparam logic [7:0] BB_RX_HOLD  = 8'h04;
  localparam logic [7:0] BB_RX_RUN   = 8'h00;

  localparam int INT_TX_BIT  = 0;
  localparam int INT_RX_BIT  = 3;
  localparam int TX_FAIL_BIT = 0;

  typedef enum logic [1:0] {
    TX_IDLE = 2'd0,
    TX_COPY = 2'd1,
    TX_SEND = 2'd2
  } tx_phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic       bus_busy;
    logic       xfer_error;
    logic       irq_line;
    logic [7:0] int_status;
    logic [7:0] rx_length;
    logic [7:0] tx_status;
    logic       reliable;
    logic [7:0] tx_frame_length;
  } in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [9:0] reg_address;
    logic [7:0] value;
    logic [8:0] xfer_count;
    logic       packet_ready;
    logic       tx_buffer_free;
    logic       tx_path_free;
    logic       tx_success;
    logic       fault;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [CountW-1:0]            count;
    out_t [MAX_RESULTS-1:0]       res;
  } plan_t;

endpackage

>>> rtl/rpds_front.sv
// rpds_front: takes requests, runs the rx/tx state machines, builds the result plan
// depends on rpds_pkg
module rpds_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  rpds_pkg::in_t  req,
  output rpds_pkg::plan_t plan
);

  rpds_pkg::tx_phase_t phase_r, phase_nxt;
  logic rx_copying_r, rx_copying_nxt;
  logic rx_pending_r, rx_pending_nxt;
  logic tx_done_r, tx_done_nxt;
  logic retry_r, retry_nxt;
  logic last_ok_r, last_ok_nxt;

  logic poll_ok, irq_tx, irq_rx, tx_fail;

  assign poll_ok = !req.bus_busy && !req.xfer_error;
  assign irq_tx  = req.irq_line && req.int_status[rpds_pkg::INT_TX_BIT];
  assign irq_rx  = req.irq_line && req.int_status[rpds_pkg::INT_RX_BIT];
  assign tx_fail = req.tx_status[rpds_pkg::TX_FAIL_BIT];

  function automatic rpds_pkg::out_t mk(input logic [2:0] act, input logic [9:0] addr,
                                        input logic [7:0] val, input logic [8:0] len);
    rpds_pkg::out_t o;
    o = '0;
    o.action      = act;
    o.reg_address = addr;
    o.value       = val;
    o.xfer_count  = len;
    return o;
  endfunction

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    rx_copying_nxt = rx_copying_r;
    rx_pending_nxt = rx_pending_r;
    tx_done_nxt    = tx_done_r;
    retry_nxt      = retry_r;
    last_ok_nxt    = last_ok_r;
    case (req.command)
      rpds_pkg::CMD_TX_START: begin
        retry_nxt = req.reliable;
        phase_nxt = rpds_pkg::TX_COPY;
      end
      rpds_pkg::CMD_RX_POLL: begin
        if (poll_ok) begin
          if (!rx_copying_r) begin
            tx_done_nxt = tx_done_r || irq_tx;
            if (rx_pending_r || irq_rx) begin
              rx_pending_nxt = 1'b0;
              rx_copying_nxt = 1'b1;
            end
          end else begin
            rx_copying_nxt = 1'b0;
          end
        end
      end
      rpds_pkg::CMD_TX_POLL: begin
        if (poll_ok) begin
          case (phase_r)
            rpds_pkg::TX_COPY: phase_nxt = rpds_pkg::TX_SEND;
            rpds_pkg::TX_SEND: begin
              rx_pending_nxt = rx_pending_r || irq_rx;
              if (tx_done_r || irq_tx) begin
                tx_done_nxt = 1'b0;
                if (!(tx_fail && retry_r)) begin
                  phase_nxt   = rpds_pkg::TX_IDLE;
                  last_ok_nxt = !tx_fail;
                end
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // result plan
  always_comb begin
    logic [rpds_pkg::CountW-1:0] cnt;
    logic [rpds_pkg::SlotW-1:0]  lst;
    logic                        ready;
    plan = '0;
    cnt  = '0;
    ready = 1'b0;
    case (req.command)
      rpds_pkg::CMD_TX_START: begin
        plan.res[0] = mk(rpds_pkg::ACT_DMA_OUT, rpds_pkg::ADDR_TXNFIFO, 8'h00,
                         {1'b0, req.tx_frame_length} + 9'd2);
        cnt = rpds_pkg::CountW'(1);
      end
      rpds_pkg::CMD_RX_POLL: begin
        if (poll_ok) begin
          if (!rx_copying_r) begin
            if (req.irq_line) begin
              plan.res[0] = mk(rpds_pkg::ACT_RD_SHORT, rpds_pkg::ADDR_INTSTAT, 8'h00, 9'd0);
              cnt = rpds_pkg::CountW'(1);
            end
            if (rx_pending_r || irq_rx) begin
              plan.res[cnt[rpds_pkg::SlotW-1:0]] =
                mk(rpds_pkg::ACT_WR_SHORT, rpds_pkg::ADDR_BBREG1, rpds_pkg::BB_RX_HOLD, 9'd0);
              plan.res[cnt[rpds_pkg::SlotW-1:0] + rpds_pkg::SlotW'(1)] =
                mk(rpds_pkg::ACT_RD_LONG, rpds_pkg::ADDR_RXFIFO, req.rx_length, 9'd0);
              plan.res[cnt[rpds_pkg::SlotW-1:0] + rpds_pkg::SlotW'(2)] =
                mk(rpds_pkg::ACT_DMA_IN, rpds_pkg::ADDR_RXFIFO + 10'd1, 8'h00,
                   {1'b0, req.rx_length});
              cnt = cnt + rpds_pkg::CountW'(3);
            end
          end else begin
            plan.res[0] = mk(rpds_pkg::ACT_WR_SHORT, rpds_pkg::ADDR_BBREG1,
                             rpds_pkg::BB_RX_RUN, 9'd0);
            cnt   = rpds_pkg::CountW'(1);
            ready = 1'b1;
          end
        end
      end
      rpds_pkg::CMD_TX_POLL: begin
        if (poll_ok) begin
          case (phase_r)
            rpds_pkg::TX_COPY: begin
              plan.res[0] = mk(rpds_pkg::ACT_WR_SHORT, rpds_pkg::ADDR_TXNCON,
                               rpds_pkg::TXN_TRIGGER, 9'd0);
              cnt = rpds_pkg::CountW'(1);
            end
            rpds_pkg::TX_SEND: begin
              if (req.irq_line) begin
                plan.res[0] = mk(rpds_pkg::ACT_RD_SHORT, rpds_pkg::ADDR_INTSTAT, 8'h00, 9'd0);
                cnt = rpds_pkg::CountW'(1);
              end
              if (tx_done_r || irq_tx) begin
                plan.res[cnt[rpds_pkg::SlotW-1:0]] =
                  mk(rpds_pkg::ACT_RD_SHORT, rpds_pkg::ADDR_TXSTAT, 8'h00, 9'd0);
                cnt = cnt + rpds_pkg::CountW'(1);
                if (tx_fail && retry_r) begin
                  plan.res[cnt[rpds_pkg::SlotW-1:0]] =
                    mk(rpds_pkg::ACT_WR_SHORT, rpds_pkg::ADDR_TXNCON,
                       rpds_pkg::TXN_TRIGGER, 9'd0);
                  cnt = cnt + rpds_pkg::CountW'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    // no action: one empty result carries the status
    if (cnt == '0) begin
      cnt = rpds_pkg::CountW'(1);
    end
    lst = rpds_pkg::SlotW'(cnt - rpds_pkg::CountW'(1));
    plan.count                   = cnt;
    plan.res[lst].packet_ready   = ready;
    plan.res[lst].tx_buffer_free = (phase_nxt != rpds_pkg::TX_COPY);
    plan.res[lst].tx_path_free   = (phase_nxt != rpds_pkg::TX_COPY) &&
                                   (phase_nxt != rpds_pkg::TX_SEND) && !req.bus_busy;
    plan.res[lst].tx_success     = last_ok_nxt;
    plan.res[lst].fault          = (req.command == rpds_pkg::CMD_RX_POLL ||
                                    req.command == rpds_pkg::CMD_TX_POLL) &&
                                   !req.bus_busy && req.xfer_error;
    plan.res[lst].last           = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= rpds_pkg::TX_IDLE;
      rx_copying_r <= 1'b0;
      rx_pending_r <= 1'b0;
      tx_done_r    <= 1'b0;
      retry_r      <= 1'b0;
      last_ok_r    <= 1'b0;
    end else if (acc) begin
      phase_r      <= phase_nxt;
      rx_copying_r <= rx_copying_nxt;
      rx_pending_r <= rx_pending_nxt;
      tx_done_r    <= tx_done_nxt;
      retry_r      <= retry_nxt;
      last_ok_r    <= last_ok_nxt;
    end
  end

endmodule

>>> rtl/rpds_queue.sv
// rpds_queue: short plan queue between front and back, flop storage
// depends on rpds_pkg
module rpds_queue #(
  parameter int Depth = rpds_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  rpds_pkg::plan_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output rpds_pkg::plan_t rd_data,
  output logic            empty
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  rpds_pkg::plan_t  mem_r [Depth];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(Depth));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(Depth - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(Depth - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/rpds_back.sv
// rpds_back: steps the queued plan into the output register, one action a cycle
// while that register is empty or being popped; depends on rpds_pkg
module rpds_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rpds_pkg::plan_t head,
  input  logic            q_empty,
  output logic            q_pop,
  output rpds_pkg::out_t  out_item,
  output logic            out_empty,
  input  logic            out_pop
);

  logic [rpds_pkg::SlotW-1:0] idx_r, idx_nxt;
  logic                       valid_r, valid_nxt;
  rpds_pkg::out_t             out_r;
  logic                       load, last_slot;

  assign load      = !q_empty && (!valid_r || out_pop);
  assign last_slot = ({1'b0, idx_r} == rpds_pkg::CountW'(head.count - rpds_pkg::CountW'(1)));
  assign q_pop     = load && last_slot;
  assign out_item  = out_r;
  assign out_empty = !valid_r;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = last_slot ? '0 : idx_r + rpds_pkg::SlotW'(1);
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= head.res[idx_r];
    end
  end

endmodule

>>> rtl/radio_packet_dma_sequencer.sv
// radio_packet_dma_sequencer: top level, front classifier, plan queue, action back end
// depends on rpds_pkg, rpds_front, rpds_queue, rpds_back
//
//   channel | ports                          | accepted when
//   request | in_item, in_push, in_full      | in_push && !in_full
//   result  | out_item, out_empty, out_pop   | out_pop && !out_empty
//
// a request is classified and its state updated in the cycle it is taken
// one to four results leave per request, one per cycle while out_pop takes them, set by the back end stepper
// a new request is taken every cycle while the plan queue has room
// results stall on out_pop without blocking the front until the queue fills
// rst_n is synchronous, active low; the first request is taken the cycle after release
module radio_packet_dma_sequencer #(
  parameter int QUEUE_DEPTH = rpds_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rpds_pkg::in_t  in_item,
  input  logic           in_push,
  output logic           in_full,
  output rpds_pkg::out_t out_item,
  output logic           out_empty,
  input  logic           out_pop
);

  rpds_pkg::plan_t plan, head;
  logic            acc, q_empty, q_pop;

  assign acc = in_push && !in_full;

  rpds_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .req   (in_item),
    .plan  (plan)
  );

  rpds_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (acc),
    .wr_data (plan),
    .full    (in_full),
    .rd_en   (q_pop),
    .rd_data (head),
    .empty   (q_empty)
  );

  rpds_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

>>> dv/radio_packet_dma_sequencer_test.sv
// radio_packet_dma_sequencer_test: self-checking testbench of the radio packet dma sequencer
// predicts the radio actions and status of every request and checks them against the results
// depends on rpds_pkg and radio_packet_dma_sequencer
module radio_packet_dma_sequencer_test;
  import rpds_pkg::*;

  localparam logic [1:0] CMD_NOOP = 2'd3;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  in_t  in_item;
  logic in_push;
  logic in_full;
  out_t out_item;
  logic out_empty;
  logic out_pop;

  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int cycle_count;

  // predicted block state
  logic      rx_copy_active;
  tx_phase_t tx_phase_model;
  logic      rx_flag;
  logic      tx_done_flag;
  logic      resend_on_fail;
  logic      tx_last_ok;

  out_t step_actions[$];
  out_t expected_actions[$];

  radio_packet_dma_sequencer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_item(in_item),
    .in_push(in_push),
    .in_full(in_full),
    .out_item(out_item),
    .out_empty(out_empty),
    .out_pop(out_pop)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void add_action(logic [2:0] act, logic [9:0] addr, logic [7:0] val,
                                     logic [8:0] len);
    out_t r;
    r = '0;
    r.action = act;
    r.reg_address = addr;
    r.value = val;
    r.xfer_count = len;
    step_actions.push_back(r);
  endfunction

  function automatic void read_int_status(logic irq, logic [7:0] stat);
    if (irq) begin
      add_action(ACT_RD_SHORT, ADDR_INTSTAT, 8'h00, 9'd0);
      if (stat[INT_TX_BIT]) tx_done_flag = 1'b1;
      if (stat[INT_RX_BIT]) rx_flag = 1'b1;
    end
  endfunction

  function automatic void predict_radio_actions(in_t req);
    logic ready;
    logic fault;
    out_t tail;
    ready = 1'b0;
    fault = 1'b0;
    step_actions.delete();
    if (req.command == CMD_TX_START) begin
      resend_on_fail = req.reliable;
      add_action(ACT_DMA_OUT, ADDR_TXNFIFO, 8'h00, {1'b0, req.tx_frame_length} + 9'd2);
      tx_phase_model = TX_COPY;
    end else if ((req.command == CMD_RX_POLL || req.command == CMD_TX_POLL) && !req.bus_busy) begin
      if (req.xfer_error) begin
        fault = 1'b1;
      end else if (req.command == CMD_RX_POLL) begin
        if (!rx_copy_active) begin
          read_int_status(req.irq_line, req.int_status);
          if (rx_flag) begin
            rx_flag = 1'b0;
            add_action(ACT_WR_SHORT, ADDR_BBREG1, BB_RX_HOLD, 9'd0);
            add_action(ACT_RD_LONG, ADDR_RXFIFO, req.rx_length, 9'd0);
            add_action(ACT_DMA_IN, ADDR_RXFIFO + 10'd1, 8'h00, {1'b0, req.rx_length});
            rx_copy_active = 1'b1;
          end
        end else begin
          add_action(ACT_WR_SHORT, ADDR_BBREG1, BB_RX_RUN, 9'd0);
          rx_copy_active = 1'b0;
          ready = 1'b1;
        end
      end else begin
        case (tx_phase_model)
          TX_COPY: begin
            add_action(ACT_WR_SHORT, ADDR_TXNCON, TXN_TRIGGER, 9'd0);
            tx_phase_model = TX_SEND;
          end
          TX_SEND: begin
            read_int_status(req.irq_line, req.int_status);
            if (tx_done_flag) begin
              tx_done_flag = 1'b0;
              add_action(ACT_RD_SHORT, ADDR_TXSTAT, 8'h00, 9'd0);
              if (req.tx_status[TX_FAIL_BIT] && resend_on_fail) begin
                add_action(ACT_WR_SHORT, ADDR_TXNCON, TXN_TRIGGER, 9'd0);
              end else begin
                tx_phase_model = TX_IDLE;
                tx_last_ok = !req.tx_status[TX_FAIL_BIT];
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
    if (step_actions.size() == 0) add_action(ACT_NONE, 10'd0, 8'h00, 9'd0);
    tail = step_actions.pop_back();
    tail.packet_ready = ready;
    tail.tx_buffer_free = (tx_phase_model != TX_COPY);
    tail.tx_path_free = (tx_phase_model == TX_IDLE) && !req.bus_busy;
    tail.tx_success = tx_last_ok;
    tail.fault = fault;
    tail.last = 1'b1;
    step_actions.push_back(tail);
    foreach (step_actions[i]) expected_actions.push_back(step_actions[i]);
  endfunction

  function automatic in_t gen_request();
    in_t r;
    r.command = ($urandom_range(99) < 4) ? CMD_NOOP : 2'($urandom_range(2));
    r.bus_busy = ($urandom_range(99) < 10);
    r.xfer_error = ($urandom_range(99) < 8);
    r.irq_line = ($urandom_range(99) < 70);
    r.int_status = 8'($urandom);
    r.rx_length = 8'($urandom);
    r.tx_status = 8'($urandom);
    r.reliable = 1'($urandom);
    r.tx_frame_length = 8'($urandom);
    return r;
  endfunction

  function automatic in_t clean_request(logic [1:0] cmd);
    in_t r;
    r = gen_request();
    r.command = cmd;
    r.bus_busy = 1'b0;
    r.xfer_error = 1'b0;
    return r;
  endfunction

  function automatic in_t plain_request(logic [1:0] cmd);
    in_t r;
    r = '0;
    r.command = cmd;
    return r;
  endfunction

  task automatic send_request(in_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      in_item <= gen_request();
      @(negedge clk);
    end
    in_item <= req;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    predict_radio_actions(req);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h actual %0h", name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_actions.size() == 0) begin
        $error("result with no request outstanding: %0h", out_item);
        errors++;
      end else begin
        want = expected_actions.pop_front();
        check_field("action", 32'(want.action), 32'(out_item.action));
        check_field("reg_address", 32'(want.reg_address), 32'(out_item.reg_address));
        check_field("value", 32'(want.value), 32'(out_item.value));
        check_field("xfer_count", 32'(want.xfer_count), 32'(out_item.xfer_count));
        check_field("packet_ready", 32'(want.packet_ready), 32'(out_item.packet_ready));
        check_field("tx_buffer_free", 32'(want.tx_buffer_free), 32'(out_item.tx_buffer_free));
        check_field("tx_path_free", 32'(want.tx_path_free), 32'(out_item.tx_path_free));
        check_field("tx_success", 32'(want.tx_success), 32'(out_item.tx_success));
        check_field("fault", 32'(want.fault), 32'(out_item.fault));
        check_field("last", 32'(want.last), 32'(out_item.last));
      end
    end
  end

  task automatic test_status_only();
    in_t r;
    send_request(plain_request(CMD_NOOP));
    r = plain_request(CMD_RX_POLL);
    r.bus_busy = 1'b1;
    r.irq_line = 1'b1;
    r.int_status = 8'hFF;
    send_request(r);
    r.command = CMD_TX_POLL;
    send_request(r);
    r = plain_request(CMD_RX_POLL);
    r.xfer_error = 1'b1;
    r.irq_line = 1'b1;
    r.int_status = 8'h08;
    send_request(r);
    r.command = CMD_TX_POLL;
    send_request(r);
    send_request(plain_request(CMD_TX_POLL));
  endtask

  task automatic test_receive_path();
    in_t r;
    send_request(plain_request(CMD_RX_POLL));
    r = plain_request(CMD_RX_POLL);
    r.irq_line = 1'b1;
    send_request(r);
    r.int_status = 8'h08;
    r.rx_length = 8'hFF;
    send_request(r);
    r = plain_request(CMD_RX_POLL);
    r.bus_busy = 1'b1;
    send_request(r);
    send_request(plain_request(CMD_RX_POLL));
    r = plain_request(CMD_RX_POLL);
    r.irq_line = 1'b1;
    r.int_status = 8'hFF;
    r.rx_length = 8'h00;
    send_request(r);
    send_request(plain_request(CMD_RX_POLL));
  endtask

  task automatic test_transmit_path();
    in_t r;
    r = plain_request(CMD_TX_START);
    r.reliable = 1'b1;
    r.tx_frame_length = 8'hFF;
    r.bus_busy = 1'b1;
    r.xfer_error = 1'b1;
    send_request(r);
    r = plain_request(CMD_TX_POLL);
    r.xfer_error = 1'b1;
    send_request(r);
    send_request(plain_request(CMD_TX_POLL));
    r = plain_request(CMD_TX_POLL);
    r.irq_line = 1'b1;
    r.int_status = 8'h01;
    r.tx_status = 8'hFF;
    send_request(r);
    r.tx_status = 8'hFE;
    send_request(r);
    r = plain_request(CMD_TX_START);
    r.tx_frame_length = 8'h00;
    send_request(r);
    send_request(r);
    send_request(plain_request(CMD_TX_POLL));
    r = plain_request(CMD_TX_POLL);
    r.irq_line = 1'b1;
    r.int_status = 8'h01;
    r.tx_status = 8'h01;
    send_request(r);
    send_request(plain_request(CMD_TX_POLL));
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int count);
    in_t r;
    int sent;
    int pick;
    int polls;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        r = clean_request(CMD_RX_POLL);
        r.irq_line = 1'b1;
        r.int_status[INT_RX_BIT] = 1'b1;
        send_request(r);
        send_request(clean_request(CMD_RX_POLL));
        sent += 2;
      end else if (pick < 70) begin
        r = gen_request();
        r.command = CMD_TX_START;
        send_request(r);
        send_request(clean_request(CMD_TX_POLL));
        polls = $urandom_range(1, 3);
        repeat (polls) begin
          r = clean_request(CMD_TX_POLL);
          r.irq_line = 1'b1;
          r.int_status[INT_TX_BIT] = 1'b1;
          send_request(r);
        end
        sent += 2 + polls;
      end else begin
        send_request(gen_request());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_item = '0;
    in_push = 1'b0;
    out_pop = 1'b0;
    errors = 0;
    cycle_count = 0;
    send_idle_pct = 6;
    recv_idle_pct = 57;
    rx_copy_active = 1'b0;
    tx_phase_model = TX_IDLE;
    rx_flag = 1'b0;
    tx_done_flag = 1'b0;
    resend_on_fail = 1'b0;
    tx_last_ok = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_status_only();
    test_receive_path();
    test_transmit_path();
    test_random_traffic(6, 57, 150);
    test_random_traffic(57, 6, 150);
    test_random_traffic(0, 0, 150);

    @(negedge clk);
    in_push <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
